// ===== design/gpiorb_pkg.sv =====
// shared constants, types and helper functions of the gpio register bank
`default_nettype none

package gpiorb_pkg;

    localparam int PIN_COUNT   = 54;

    localparam int FSEL_WORDS  = 6;
    localparam int FSEL_FIELDS = 10;
    localparam int FSEL_BITS   = 3 * FSEL_FIELDS;
    localparam int FSEL_IDX_W  = $clog2(FSEL_WORDS);
    localparam int PULL_WORDS  = 4;
    localparam int PULL_FIELDS = 16;
    localparam int PULL_IDX_W  = $clog2(PULL_WORDS);
    localparam int WORD_W      = 32;
    localparam int OFFSET_W    = 6;

    localparam logic [OFFSET_W-1:0] FSEL_FIRST = 6'd0;
    localparam logic [OFFSET_W-1:0] FSEL_LAST  = 6'd5;
    localparam logic [OFFSET_W-1:0] SET_LO     = 6'd7;
    localparam logic [OFFSET_W-1:0] SET_HI     = 6'd8;
    localparam logic [OFFSET_W-1:0] CLR_LO     = 6'd10;
    localparam logic [OFFSET_W-1:0] CLR_HI     = 6'd11;
    localparam logic [OFFSET_W-1:0] PULL_FIRST = 6'd57;
    localparam logic [OFFSET_W-1:0] PULL_LAST  = 6'd60;

    localparam logic       ACT_READ    = 1'b0;
    localparam logic       ACT_WRITE   = 1'b1;
    localparam logic [2:0] CODE_OUTPUT = 3'b001;

    typedef enum logic [2:0] {
        REG_FSEL,
        REG_PULL,
        REG_SET,
        REG_CLR,
        REG_NONE
    } t_region;

    typedef struct packed {
        logic                action;
        logic [OFFSET_W-1:0] word_offset;
        logic [WORD_W-1:0]   write_data;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]    read_data;
        logic                 bad_offset;
        logic [PIN_COUNT-1:0] pin_level;
        logic [PIN_COUNT-1:0] pin_drive_enable;
    } t_rsp;

    // bits of function word w that belong to existing pins
    function automatic logic [FSEL_BITS-1:0] fsel_mask(input int w);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int f = 0; f < FSEL_FIELDS; f++) begin
            if (w * FSEL_FIELDS + f < PIN_COUNT) begin
                m[3*f +: 3] = 3'b111;
            end
        end
        return m;
    endfunction

    // bits of pull word p that belong to existing pins
    function automatic logic [WORD_W-1:0] pull_mask(input int p);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int f = 0; f < PULL_FIELDS; f++) begin
            if (p * PULL_FIELDS + f < PIN_COUNT) begin
                m[2*f +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== design/gpiorb_if.sv =====
// valid/ready channel interfaces for register accesses and their results
`default_nettype none

interface gpiorb_req_if import gpiorb_pkg::*;;
    logic                valid;
    logic                ready;
    logic                action;
    logic [OFFSET_W-1:0] word_offset;
    logic [WORD_W-1:0]   write_data;

    modport source (output valid, output action, output word_offset, output write_data,
                    input ready);
    modport sink   (input valid, input action, input word_offset, input write_data,
                    output ready);
endinterface

interface gpiorb_rsp_if import gpiorb_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    read_data;
    logic                 bad_offset;
    logic [PIN_COUNT-1:0] pin_level;
    logic [PIN_COUNT-1:0] pin_drive_enable;

    modport source (output valid, output read_data, output bad_offset, output pin_level,
                    output pin_drive_enable, input ready);
    modport sink   (input valid, input read_data, input bad_offset, input pin_level,
                    input pin_drive_enable, output ready);
endinterface

`default_nettype wire

// ===== design/gpiorb_regs.sv =====
// register stores, offset decode and update for one access
`default_nettype none

module gpiorb_regs import gpiorb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_commit,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    logic [FSEL_BITS-1:0]  r_fsel [FSEL_WORDS];
    logic [FSEL_BITS-1:0]  n_fsel [FSEL_WORDS];
    logic [WORD_W-1:0]     r_pull [PULL_WORDS];
    logic [WORD_W-1:0]     n_pull [PULL_WORDS];
    logic [PIN_COUNT-1:0]  r_latch;
    logic [PIN_COUNT-1:0]  n_latch;

    t_region               region;
    logic [FSEL_IDX_W-1:0] fsel_idx;
    logic [PULL_IDX_W-1:0] pull_idx;
    logic                  is_write;
    logic [2*WORD_W-1:0]   wide;
    logic [PIN_COUNT-1:0]  lane;
    logic [PIN_COUNT-1:0]  drive_en;

    always_comb begin
        priority if (i_req.word_offset >= FSEL_FIRST && i_req.word_offset <= FSEL_LAST) begin
            region = REG_FSEL;
        end else if (i_req.word_offset >= PULL_FIRST && i_req.word_offset <= PULL_LAST) begin
            region = REG_PULL;
        end else if (i_req.word_offset == SET_LO || i_req.word_offset == SET_HI) begin
            region = REG_SET;
        end else if (i_req.word_offset == CLR_LO || i_req.word_offset == CLR_HI) begin
            region = REG_CLR;
        end else begin
            region = REG_NONE;
        end
    end

    assign fsel_idx = FSEL_IDX_W'(i_req.word_offset - FSEL_FIRST);
    assign pull_idx = PULL_IDX_W'(i_req.word_offset - PULL_FIRST);
    assign is_write = (i_req.action == ACT_WRITE);

    // upper half of the latch for the second set or clear word
    assign wide = (i_req.word_offset == SET_HI || i_req.word_offset == CLR_HI)
                ? {i_req.write_data, {WORD_W{1'b0}}}
                : {{WORD_W{1'b0}}, i_req.write_data};
    assign lane = wide[PIN_COUNT-1:0];

    always_comb begin
        for (int w = 0; w < FSEL_WORDS; w++) begin
            n_fsel[w] = r_fsel[w];
            if (is_write && region == REG_FSEL && fsel_idx == FSEL_IDX_W'(w)) begin
                n_fsel[w] = i_req.write_data[FSEL_BITS-1:0] & fsel_mask(w);
            end
        end
        for (int p = 0; p < PULL_WORDS; p++) begin
            n_pull[p] = r_pull[p];
            if (is_write && region == REG_PULL && pull_idx == PULL_IDX_W'(p)) begin
                n_pull[p] = i_req.write_data & pull_mask(p);
            end
        end
    end

    always_comb begin
        n_latch = r_latch;
        if (is_write && region == REG_SET) begin
            n_latch = r_latch | lane;
        end else if (is_write && region == REG_CLR) begin
            n_latch = r_latch & ~lane;
        end
    end

    for (genvar pin = 0; pin < PIN_COUNT; pin++) begin : g_drive
        localparam int W = pin / FSEL_FIELDS;
        localparam int S = (pin % FSEL_FIELDS) * 3;
        assign drive_en[pin] = (n_fsel[W][S +: 3] == CODE_OUTPUT);
    end

    always_comb begin
        o_rsp.read_data = '0;
        unique case (region)
            REG_FSEL: begin
                if (!is_write) begin
                    o_rsp.read_data = WORD_W'(r_fsel[fsel_idx]);
                end
            end
            REG_PULL: begin
                if (!is_write) begin
                    o_rsp.read_data = r_pull[pull_idx];
                end
            end
            default: o_rsp.read_data = '0;
        endcase
        o_rsp.bad_offset       = (region == REG_NONE);
        o_rsp.pin_level        = n_latch;
        o_rsp.pin_drive_enable = drive_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
            for (int p = 0; p < PULL_WORDS; p++) begin
                r_pull[p] <= '0;
            end
            r_latch <= '0;
        end else if (i_commit) begin
            r_fsel  <= n_fsel;
            r_pull  <= n_pull;
            r_latch <= n_latch;
        end
    end

endmodule

`default_nettype wire

// ===== design/gpio_register_bank.sv =====
// top level of the gpio register bank: input register, register stores, result register
//
// One request channel (i_req) carries register accesses: action (read or write),
// 6-bit offset of a 32-bit word and write data. One result channel (o_rsp) returns,
// for every accepted beat, the read data, the unmapped-offset flag, the output latch
// and the per-pin drive enables as they stand after that access.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted beat goes first into the input register and shows its result
// once the result register takes it.
// Throughput: one access per cycle while the receiver takes results, set by the
// single decode-and-update path between the two registers.
// When the receiver holds ready low the result register keeps its beat, the
// input register fills, and i_req.ready drops until the result is taken; no
// access is committed to the stores before its result has a free slot.
// Synchronous reset (i_rst_n low) empties both registers, sets every pin to
// input, clears the pull words and clears the output latch.
`default_nettype none

module gpio_register_bank import gpiorb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gpiorb_req_if.sink   i_req,
    gpiorb_rsp_if.source o_rsp
);

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    logic out_free;
    logic commit;
    t_rsp rsp_next;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign commit      = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in.action      <= i_req.action;
            r_in.word_offset <= i_req.word_offset;
            r_in.write_data  <= i_req.write_data;
        end
    end

    gpiorb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_req    (r_in),
        .o_rsp    (rsp_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= rsp_next;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out.read_data;
    assign o_rsp.bad_offset       = r_out.bad_offset;
    assign o_rsp.pin_level        = r_out.pin_level;
    assign o_rsp.pin_drive_enable = r_out.pin_drive_enable;

endmodule

`default_nettype wire

// ===== test/tb_gpio_register_bank.sv =====
// self-checking testbench of the gpio register bank with a register-level predictor
`default_nettype none

module tb_gpio_register_bank;
    import gpiorb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ACCESSES = 400;
    localparam int QUIET_LIMIT     = 2000;

    localparam logic [OFFSET_W-1:0] OFF_HOLE_LOW   = 6'd6;
    localparam logic [OFFSET_W-1:0] OFF_HOLE_MID   = 6'd9;
    localparam logic [OFFSET_W-1:0] OFF_ABOVE_CLR  = 6'd12;
    localparam logic [OFFSET_W-1:0] OFF_BELOW_PULL = 6'd56;
    localparam logic [OFFSET_W-1:0] OFF_TOP        = 6'd63;

    localparam t_rsp RSP_ZERO = '0;
    localparam t_rsp RSP_BAD  = '{read_data: '0, bad_offset: 1'b1, pin_level: '0,
                                  pin_drive_enable: '0};

    typedef struct {
        logic                action;
        logic [OFFSET_W-1:0] word_offset;
        logic [WORD_W-1:0]   write_data;
        bit                  fixed;
        t_rsp                rsp;
    } t_access_row;

    typedef struct {
        bit   fixed;
        t_rsp rsp;
    } t_hand_result;

    // hand-written results only where they are obvious
    t_access_row access_table [25] = '{
        '{ACT_READ,  FSEL_FIRST,     32'h0000_0000, 1'b1, RSP_ZERO},
        '{ACT_READ,  FSEL_LAST,      32'h0000_0000, 1'b1, RSP_ZERO},
        '{ACT_READ,  PULL_FIRST,     32'h0000_0000, 1'b1, RSP_ZERO},
        '{ACT_READ,  PULL_LAST,      32'h0000_0000, 1'b1, RSP_ZERO},
        '{ACT_READ,  SET_LO,         32'hFFFF_FFFF, 1'b1, RSP_ZERO},
        '{ACT_READ,  CLR_HI,         32'hFFFF_FFFF, 1'b1, RSP_ZERO},
        '{ACT_READ,  OFF_HOLE_LOW,   32'h0000_0000, 1'b1, RSP_BAD},
        '{ACT_WRITE, OFF_TOP,        32'hFFFF_FFFF, 1'b1, RSP_BAD},
        '{ACT_WRITE, OFF_BELOW_PULL, 32'hFFFF_FFFF, 1'b1, RSP_BAD},
        '{ACT_READ,  OFF_HOLE_MID,   32'h0000_0000, 1'b1, RSP_BAD},
        '{ACT_WRITE, FSEL_FIRST,     32'hFFFF_FFFF, 1'b1, RSP_ZERO},
        '{ACT_READ,  FSEL_FIRST,     32'h0000_0000, 1'b0, RSP_ZERO},
        '{ACT_WRITE, FSEL_FIRST,     32'h0924_9249, 1'b0, RSP_ZERO},
        '{ACT_WRITE, FSEL_LAST,      32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_READ,  FSEL_LAST,      32'h0000_0000, 1'b0, RSP_ZERO},
        '{ACT_WRITE, FSEL_LAST,      32'h0000_0249, 1'b0, RSP_ZERO},
        '{ACT_WRITE, SET_LO,         32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_WRITE, SET_HI,         32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_READ,  SET_HI,         32'h0000_0000, 1'b0, RSP_ZERO},
        '{ACT_WRITE, CLR_LO,         32'hAAAA_AAAA, 1'b0, RSP_ZERO},
        '{ACT_WRITE, CLR_HI,         32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_WRITE, PULL_FIRST,     32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_WRITE, PULL_LAST,      32'hFFFF_FFFF, 1'b0, RSP_ZERO},
        '{ACT_READ,  PULL_LAST,      32'h0000_0000, 1'b0, RSP_ZERO},
        '{ACT_READ,  OFF_ABOVE_CLR,  32'h0000_0000, 1'b0, RSP_ZERO}
    };

    logic clk;
    logic rst_n;

    gpiorb_req_if req_bus ();
    gpiorb_rsp_if rsp_bus ();

    gpio_register_bank u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    logic [FSEL_BITS-1:0] fsel_shadow [FSEL_WORDS] = '{default: '0};
    logic [WORD_W-1:0]    pull_shadow [PULL_WORDS] = '{default: '0};
    logic [PIN_COUNT-1:0] latch_shadow = '0;

    t_rsp         pending_reports [$];
    t_hand_result hand_results [$];
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // applies one access to the shadow registers and returns the expected result beat with its pin report
    function automatic t_rsp apply_access(input t_req acc);
        t_rsp                 r;
        int                   idx;
        logic [WORD_W-1:0]    keep;
        logic [2*WORD_W-1:0]  bits;
        r    = '0;
        keep = '0;
        bits = {{WORD_W{1'b0}}, acc.write_data};
        if (acc.word_offset >= FSEL_FIRST && acc.word_offset <= FSEL_LAST) begin
            idx = int'(acc.word_offset - FSEL_FIRST);
            if (acc.action == ACT_WRITE) begin
                for (int f = 0; f < 10; f++) begin
                    if (idx * 10 + f < PIN_COUNT) keep[3*f +: 3] = 3'b111;
                end
                fsel_shadow[idx] = acc.write_data[FSEL_BITS-1:0] & keep[FSEL_BITS-1:0];
            end else begin
                r.read_data = WORD_W'(fsel_shadow[idx]);
            end
        end else if (acc.word_offset >= PULL_FIRST && acc.word_offset <= PULL_LAST) begin
            idx = int'(acc.word_offset - PULL_FIRST);
            if (acc.action == ACT_WRITE) begin
                for (int f = 0; f < 16; f++) begin
                    if (idx * 16 + f < PIN_COUNT) keep[2*f +: 2] = 2'b11;
                end
                pull_shadow[idx] = acc.write_data & keep;
            end else begin
                r.read_data = pull_shadow[idx];
            end
        end else if (acc.word_offset == SET_LO || acc.word_offset == SET_HI) begin
            if (acc.action == ACT_WRITE) begin
                if (acc.word_offset == SET_HI) bits = bits << WORD_W;
                latch_shadow = latch_shadow | bits[PIN_COUNT-1:0];
            end
        end else if (acc.word_offset == CLR_LO || acc.word_offset == CLR_HI) begin
            if (acc.action == ACT_WRITE) begin
                if (acc.word_offset == CLR_HI) bits = bits << WORD_W;
                latch_shadow = latch_shadow & ~bits[PIN_COUNT-1:0];
            end
        end else begin
            r.bad_offset = 1'b1;
        end
        r.pin_level = latch_shadow;
        for (int pin = 0; pin < PIN_COUNT; pin++) begin
            if (fsel_shadow[pin / 10][(pin % 10) * 3 +: 3] == CODE_OUTPUT) begin
                r.pin_drive_enable[pin] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_req random_access();
        t_req acc;
        int   pick;
        acc.action = $urandom_range(1) ? ACT_WRITE : ACT_READ;
        if ($urandom_range(99) < 15) begin
            acc.word_offset = OFFSET_W'($urandom_range(63));
        end else begin
            pick = $urandom_range(13);
            if (pick < 6)       acc.word_offset = FSEL_FIRST + OFFSET_W'(pick);
            else if (pick < 8)  acc.word_offset = SET_LO + OFFSET_W'(pick - 6);
            else if (pick < 10) acc.word_offset = CLR_LO + OFFSET_W'(pick - 8);
            else                acc.word_offset = PULL_FIRST + OFFSET_W'(pick - 10);
        end
        acc.write_data = $urandom;
        case ($urandom_range(9))
            0: acc.write_data = '1;
            1: acc.write_data = '0;
            2, 3, 4: begin
                // dense output codes so that drive enables toggle often
                for (int f = 0; f < 10; f++) begin
                    if ($urandom_range(1)) acc.write_data[3*f +: 3] = CODE_OUTPUT;
                end
            end
            default: ;
        endcase
        return acc;
    endfunction

    task automatic sender_gap(input bit calm);
        if (!calm) begin
            while ($urandom_range(99) < 23) begin
                req_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic offer_access(input t_req acc);
        req_bus.valid       <= 1'b1;
        req_bus.action      <= acc.action;
        req_bus.word_offset <= acc.word_offset;
        req_bus.write_data  <= acc.write_data;
        do @(posedge clk); while (!req_bus.ready);
    endtask

    initial begin : drive_accesses
        t_req acc;
        req_bus.valid       <= 1'b0;
        req_bus.action      <= ACT_READ;
        req_bus.word_offset <= '0;
        req_bus.write_data  <= '0;
        do @(posedge clk); while (!rst_n);

        foreach (access_table[i]) begin
            sender_gap(1'b0);
            hand_results.push_back('{access_table[i].fixed, access_table[i].rsp});
            acc = '{access_table[i].action, access_table[i].word_offset,
                    access_table[i].write_data};
            offer_access(acc);
        end

        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n == 250) begin
                // hold back until every outstanding report is back
                req_bus.valid <= 1'b0;
                do @(posedge clk); while (pending_reports.size() != 0);
            end
            sender_gap(n >= 100 && n < 180);
            hand_results.push_back('{1'b0, RSP_ZERO});
            offer_access(random_access());
        end
        req_bus.valid <= 1'b0;

        do @(posedge clk); while (pending_reports.size() != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : take_reports
        int cyc;
        int hold_left;
        rsp_bus.ready <= 1'b0;
        cyc       = 0;
        hold_left = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            // long hold-off fills the block and stalls the request side
            if (cyc == 250) hold_left = 64;
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (cyc >= 450 && cyc < 650) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= 23);
            end
            cyc++;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_beats
        t_rsp         want;
        t_rsp         got;
        t_hand_result hand;
        bit           moved;
        moved = 1'b0;
        if (rst_n) begin
            if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
                moved = 1'b1;
                want  = apply_access('{req_bus.action, req_bus.word_offset,
                                       req_bus.write_data});
                if (hand_results.size() != 0) begin
                    hand = hand_results.pop_front();
                    if (hand.fixed) want = hand.rsp;
                end
                pending_reports.push_back(want);
            end
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                moved = 1'b1;
                got   = '{rsp_bus.read_data, rsp_bus.bad_offset, rsp_bus.pin_level,
                          rsp_bus.pin_drive_enable};
                if (pending_reports.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    want = pending_reports.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  got.read_data, want.read_data));
                    if (got.bad_offset !== want.bad_offset)
                        report_mismatch($sformatf("bad_offset %b, want %b",
                                                  got.bad_offset, want.bad_offset));
                    if (got.pin_level !== want.pin_level)
                        report_mismatch($sformatf("pin_level %h, want %h",
                                                  got.pin_level, want.pin_level));
                    if (got.pin_drive_enable !== want.pin_drive_enable)
                        report_mismatch($sformatf("pin_drive_enable %h, want %h",
                                                  got.pin_drive_enable,
                                                  want.pin_drive_enable));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/gpiorb_pkg.sv
design/gpiorb_if.sv
design/gpiorb_regs.sv
design/gpio_register_bank.sv
test/tb_gpio_register_bank.sv
